### design/gbn_pkg.sv
package gbn_pkg;

	localparam int MaxDegree = 64;
	localparam int RowAw     = 6;   // index of a row or a column
	localparam int CntW      = 7;   // holds 0..MaxDegree

	typedef logic [MaxDegree-1:0] row_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;    // latch a new polynomial
		logic build;   // one step of the x^k mod p register
		logic piv;     // pivot search on the row just read
		logic elim;    // sweep rows below the pivot row
		logic bas;     // sweep pivot map to form a basis vector
		logic bwr;     // store the basis vector
		logic knext;   // advance to the next row
		logic oload;   // load the output register
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic deg_zero;
		logic build_last;
		logic piv_found;
		logic scan_done;
		logic k_last;
		logic out_fire;
		logic out_last;
	} sts_t;

	function automatic logic [RowAw-1:0] lowest_one(input row_t v);
		logic [RowAw-1:0] idx;
		idx = '0;
		for (int i = MaxDegree - 1; i >= 0; i--) begin
			if (v[i]) idx = RowAw'(i);
		end
		return idx;
	endfunction

endpackage

### design/gbn_ram.sv
module gbn_ram #(
	parameter int Width = 64,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

### design/gbn_ctrl.sv
module gbn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  gbn_pkg::sts_t sts,
	output gbn_pkg::cmd_t cmd,
	output logic          idle
);

	typedef enum logic [10:0] {
		IDLE  = 11'b000_0000_0001,
		BUILD = 11'b000_0000_0010,
		RDK   = 11'b000_0000_0100,
		PIV   = 11'b000_0000_1000,
		ELIM  = 11'b000_0001_0000,
		BAS   = 11'b000_0010_0000,
		BWR   = 11'b000_0100_0000,
		KNEXT = 11'b000_1000_0000,
		ORD   = 11'b001_0000_0000,
		OLD   = 11'b010_0000_0000,
		OWAIT = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= IDLE;
		else state_q <= state_d;
	end

	assign idle = (state_q == IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			IDLE: begin
				if (in_fire && !sts.deg_zero) begin
					cmd.load = 1'b1;
					state_d  = BUILD;
				end
			end
			BUILD: begin
				cmd.build = 1'b1;
				if (sts.build_last) state_d = RDK;
			end
			RDK: begin
				state_d = PIV;
			end
			PIV: begin
				cmd.piv = 1'b1;
				state_d = sts.piv_found ? ELIM : BAS;
			end
			ELIM: begin
				cmd.elim = 1'b1;
				if (sts.scan_done) state_d = KNEXT;
			end
			BAS: begin
				cmd.bas = 1'b1;
				if (sts.scan_done) state_d = BWR;
			end
			BWR: begin
				cmd.bwr = 1'b1;
				state_d = KNEXT;
			end
			KNEXT: begin
				cmd.knext = 1'b1;
				state_d   = sts.k_last ? ORD : RDK;
			end
			ORD: begin
				state_d = OLD;
			end
			OLD: begin
				cmd.oload = 1'b1;
				state_d   = OWAIT;
			end
			OWAIT: begin
				if (sts.out_fire) state_d = sts.out_last ? IDLE : ORD;
			end
			default: state_d = IDLE;
		endcase
	end

endmodule

### design/gbn_dp.sv
module gbn_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gbn_pkg::cmd_t                 cmd,
	output gbn_pkg::sts_t                 sts,
	input  logic [gbn_pkg::CntW-1:0]      degree,
	input  gbn_pkg::row_t                 low_coeffs,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gbn_pkg::RowAw-1:0]     row_index,
	output gbn_pkg::row_t                 basis_vector,
	output logic [gbn_pkg::CntW-1:0]      basis_count,
	output logic                          last_row
);

	localparam int AW = gbn_pkg::RowAw;
	localparam int CW = gbn_pkg::CntW;

	logic [CW-1:0]  n_q, k_q, cnt_q, rd_q;
	logic [CW:0]    step_q;
	gbn_pkg::row_t  poly_q, mask_q, shift_q, pivoted_q, rowk_q, vec_q;
	logic [AW-1:0]  col_q, wa_q;
	logic           iv_q;

	logic [CW-1:0]  n_sat;
	gbn_pkg::row_t  cand, others, mat_rdata, bas_rdata;
	logic [AW-1:0]  piv_col, mat_raddr, mat_waddr, pm_rdata, top_idx, brow;
	gbn_pkg::row_t  mat_wdata;
	logic           mat_we, found, issue, top;

	assign n_sat   = (degree > CW'(gbn_pkg::MaxDegree)) ? CW'(gbn_pkg::MaxDegree) : degree;
	assign cand    = mat_rdata & ~pivoted_q;
	assign found   = |cand;
	assign piv_col = gbn_pkg::lowest_one(cand);
	assign others  = rowk_q & ~(gbn_pkg::row_t'(1) << col_q);
	assign top_idx = AW'(n_q - CW'(1));
	assign top     = shift_q[top_idx];
	assign brow    = step_q[AW:1];
	assign issue   = (rd_q < n_q);

	// one write port shared by build, pivot and elimination
	always_comb begin
		mat_we    = 1'b0;
		mat_waddr = k_q[AW-1:0];
		mat_wdata = gbn_pkg::row_t'(1) << piv_col;
		if (cmd.build && !step_q[0]) begin
			mat_we    = 1'b1;
			mat_waddr = brow;
			mat_wdata = shift_q ^ (gbn_pkg::row_t'(1) << brow);
		end else if (cmd.piv && found) begin
			mat_we = 1'b1;
		end else if (cmd.elim && iv_q && mat_rdata[col_q]) begin
			mat_we    = 1'b1;
			mat_waddr = wa_q;
			mat_wdata = mat_rdata ^ others;
		end
	end

	assign mat_raddr = cmd.elim ? rd_q[AW-1:0] : k_q[AW-1:0];

	gbn_ram #(.Width(gbn_pkg::MaxDegree), .Depth(gbn_pkg::MaxDegree)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(mat_wdata),
		.raddr(mat_raddr), .rdata(mat_rdata)
	);

	gbn_ram #(.Width(AW), .Depth(gbn_pkg::MaxDegree)) u_pmap (
		.clk(clk), .we(cmd.piv && found), .waddr(piv_col), .wdata(k_q[AW-1:0]),
		.raddr(rd_q[AW-1:0]), .rdata(pm_rdata)
	);

	gbn_ram #(.Width(gbn_pkg::MaxDegree), .Depth(gbn_pkg::MaxDegree)) u_bas (
		.clk(clk), .we(cmd.bwr), .waddr(cnt_q[AW-1:0]), .wdata(vec_q),
		.raddr(rd_q[AW-1:0]), .rdata(bas_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0; k_q <= '0; cnt_q <= '0; rd_q <= '0; step_q <= '0;
			poly_q <= '0; mask_q <= '0; shift_q <= '0; pivoted_q <= '0;
			rowk_q <= '0; vec_q <= '0; col_q <= '0; wa_q <= '0; iv_q <= 1'b0;
			out_valid <= 1'b0; row_index <= '0; basis_vector <= '0;
			basis_count <= '0; last_row <= 1'b0;
		end else begin
			if (cmd.load) begin
				n_q       <= n_sat;
				mask_q    <= ~({gbn_pkg::MaxDegree{1'b1}} << n_sat);
				poly_q    <= low_coeffs & ~({gbn_pkg::MaxDegree{1'b1}} << n_sat);
				shift_q   <= gbn_pkg::row_t'(1);
				step_q    <= '0;
				k_q       <= '0;
				cnt_q     <= '0;
				pivoted_q <= '0;
			end
			if (cmd.build) begin
				shift_q <= ((shift_q << 1) & mask_q) ^ (top ? poly_q : '0);
				step_q  <= step_q + (CW+1)'(1);
			end
			if (cmd.piv) begin
				rowk_q <= mat_rdata;
				col_q  <= piv_col;
				vec_q  <= gbn_pkg::row_t'(1) << k_q[AW-1:0];
				iv_q   <= 1'b0;
				if (found) begin
					pivoted_q[piv_col] <= 1'b1;
					rd_q <= k_q + CW'(1);
				end else begin
					rd_q <= '0;
				end
			end
			if (cmd.elim || cmd.bas) begin
				iv_q <= issue;
				wa_q <= rd_q[AW-1:0];
				if (issue) rd_q <= rd_q + CW'(1);
			end
			// pick up the pivot row of each pivoted column set in this row
			if (cmd.bas && iv_q && pivoted_q[wa_q] && rowk_q[wa_q])
				vec_q <= vec_q | (gbn_pkg::row_t'(1) << pm_rdata);
			if (cmd.bwr) cnt_q <= cnt_q + CW'(1);
			if (cmd.knext) begin
				k_q  <= k_q + CW'(1);
				rd_q <= '0;
			end
			if (cmd.oload) begin
				out_valid    <= 1'b1;
				row_index    <= rd_q[AW-1:0];
				basis_vector <= (rd_q < cnt_q) ? bas_rdata : '0;
				basis_count  <= cnt_q;
				last_row     <= (rd_q + CW'(1) == n_q);
				rd_q         <= rd_q + CW'(1);
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.deg_zero   = (degree == '0);
	assign sts.build_last = (step_q == (({1'b0, n_q} << 1) - (CW+1)'(1)));
	assign sts.piv_found  = found;
	assign sts.scan_done  = !issue && !iv_q;
	assign sts.k_last     = (k_q + CW'(1) == n_q);
	assign sts.out_fire   = out_valid && out_ready;
	assign sts.out_last   = last_row;

	a_elim_below : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.elim && mat_we) |-> ({1'b0, wa_q} > k_q))
		else $error("elimination writes at or above the pivot row");

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'($countones(pivoted_q)) + {1'b0, cnt_q} <= {1'b0, k_q} + (CW+1)'(1))
		else $error("pivots plus basis vectors exceed rows processed");

	a_out_row : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, row_index} < n_q))
		else $error("output row beyond degree");

	a_zero_tail : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ({1'b0, row_index} >= basis_count)) |-> (basis_vector == '0))
		else $error("nonzero row past basis count");

endmodule

### design/gf2_berlekamp_nullspace.sv
// channel   dir  tdata fields (low bit up)                        tuser  tlast
// s_axis    in   degree[6:0], low_coeffs[70:7], pad[71]            -      -
// m_axis    out  row_index[5:0], basis_vector[69:6],              -      last_row
//                basis_count[76:70], pad[79:77]
//
// One polynomial of degree n is first built into the matrix, row by row;
// then each row k gets a pivot search and, when a pivot is found, a sweep
// of the rows below it, or else a sweep of the pivot map for a null row.
// The matrix RAM has one write port and one read port. Then the output
// rows are sent one at a time.
// Reset clears all control state; the RAMs need no clearing.
// A new transaction is taken only when the last row has been delivered.
// The output register holds a row stable while m_axis_tready is low.
module gf2_berlekamp_nullspace (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // degree, low_coeffs
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // row_index, basis_vector, basis_count
	output logic        m_axis_tlast
);

	gbn_pkg::cmd_t                 cmd;
	gbn_pkg::sts_t                 sts;
	logic                          idle;
	logic [gbn_pkg::RowAw-1:0]     row_index;
	gbn_pkg::row_t                 basis_vector;
	logic [gbn_pkg::CntW-1:0]      basis_count;

	// accept only while idle; degree zero transactions are dropped
	assign s_axis_tready = idle;

	gbn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.sts(sts), .cmd(cmd), .idle(idle)
	);

	gbn_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.degree(s_axis_tdata[6:0]), .low_coeffs(s_axis_tdata[70:7]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.row_index(row_index), .basis_vector(basis_vector),
		.basis_count(basis_count), .last_row(m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, basis_count, basis_vector, row_index};

endmodule
